// ===== hdl/tcw_pkg.sv =====
package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;

    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ADDR_W = $clog2(CELL_COUNT);

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_SET   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [7:0] NEWLINE_CODE   = 8'd10;
    localparam logic [7:0] BACKSPACE_CODE = 8'd8;
    localparam logic [7:0] SPACE_CODE     = 8'h20;
    localparam logic [7:0] RESET_COLOR    = 8'h07;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             wr_en;
        logic [ROW_W-1:0] wr_row;
        logic [COL_W-1:0] wr_col;
        logic [15:0]      wr_data;
        logic             rd;
        logic             scroll;
        logic             clear;
    } t_cursor_upd;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        cell_addr = ADDR_W'(int'(row) * COLUMNS + int'(col));
    endfunction

endpackage

// ===== hdl/text_console_writer.sv =====
// Text-mode console with a ROWS x COLUMNS screen of 16-bit cells (color byte high,
// character low) kept in a single-port-write, registered-read memory. Every request
// (put, set cursor, read cell, clear) returns one result with the cursor after it.
// A scroll walks the memory one cell per cycle through the write port, copying
// CELL_COUNT - COLUMNS cells up by one row and then filling the last COLUMNS cells;
// a clear fills all CELL_COUNT cells. After reset a clearing pass over all CELL_COUNT
// cells (2000 by default) fills the screen with light grey spaces while o_in_stall
// stays high; configuration writes are taken at any time. The color register is at
// byte address 0.
module text_console_writer
    import tcw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_char_code,
    input  logic [7:0]  i_row_in,
    input  logic [7:0]  i_column_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_cell_word,
    output logic [4:0]  o_cursor_row,
    output logic [6:0]  o_cursor_column,
    output logic [10:0] o_cursor_position,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_SCRL   = 3'd2;
    localparam logic [2:0] S_FILL   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    localparam logic              REG_TEXT_COLOR = 1'b0;
    localparam logic [ADDR_W-1:0] LAST_COPY  = ADDR_W'(CELL_COUNT - COLUMNS - 1);
    localparam logic [ADDR_W-1:0] FILL_START = ADDR_W'(CELL_COUNT - COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);
    localparam logic [15:0]       RESET_CELL = {RESET_COLOR, SPACE_CODE};

    logic [2:0]        r_state, n_state;
    logic [1:0]        r_op;
    logic [7:0]        r_char;
    logic [ROW_W-1:0]  r_req_row, r_row;
    logic [COL_W-1:0]  r_req_col, r_col;
    logic [7:0]        r_color;
    logic [ADDR_W-1:0] r_idx, idx_next;
    logic [15:0]       r_fill, r_rdata;
    logic              r_init;
    logic              r_out_valid;
    logic [15:0]       r_cell_word;
    logic [4:0]        r_out_row;
    logic [6:0]        r_out_col;
    logic [10:0]       r_out_pos;

    logic [15:0]       mem [CELL_COUNT];
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [15:0]       mem_wdata;

    logic              in_accept, out_load, cfg_write;
    t_cursor_upd       upd;

    tcw_cursor u_cursor (
        .i_op      (r_op),
        .i_char    (r_char),
        .i_row     (r_row),
        .i_col     (r_col),
        .i_req_row (r_req_row),
        .i_req_col (r_req_col),
        .i_color   (r_color),
        .o_upd     (upd)
    );

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_load  = (r_state == S_FINISH) && (!r_out_valid || !i_out_stall);
    assign cfg_write = psel && penable && pwrite && pready;
    assign idx_next  = r_idx + 1'b1;

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_cell_word       = r_cell_word;
    assign o_cursor_row      = r_out_row;
    assign o_cursor_column   = r_out_col;
    assign o_cursor_position = r_out_pos;
    assign pready            = 1'b1;
    assign prdata            = (paddr[2] == REG_TEXT_COLOR) ? {24'd0, r_color} : 32'd0;

    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = r_idx;
        mem_raddr = idx_next + ROW_STRIDE;
        mem_wdata = r_fill;
        unique case (r_state)
            S_EXEC: begin
                mem_we    = upd.wr_en;
                mem_waddr = cell_addr(upd.wr_row, upd.wr_col);
                mem_wdata = upd.wr_data;
                mem_re    = upd.rd || upd.scroll;
                mem_raddr = upd.rd ? cell_addr(r_req_row, r_req_col) : ROW_STRIDE;
            end
            S_SCRL: begin
                mem_we    = 1'b1;
                mem_wdata = r_rdata;
                mem_re    = (r_idx != LAST_COPY);
            end
            S_FILL: begin
                mem_we = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (upd.scroll) begin
                    n_state = S_SCRL;
                end else if (upd.clear) begin
                    n_state = S_FILL;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_SCRL: begin
                if (r_idx == LAST_COPY) n_state = S_FILL;
            end
            S_FILL: begin
                if (r_idx == LAST_CELL) n_state = r_init ? S_IDLE : S_FINISH;
            end
            S_FINISH: begin
                if (out_load) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_idx       <= '0;
            r_fill      <= RESET_CELL;
            r_init      <= 1'b1;
            r_row       <= '0;
            r_col       <= '0;
            r_color     <= RESET_COLOR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_write && (paddr[2] == REG_TEXT_COLOR)) begin
                r_color <= pwdata[7:0];
            end
            if (in_accept) begin
                r_op      <= i_op;
                r_char    <= i_char_code;
                r_req_row <= (i_row_in >= 8'(ROWS)) ? LAST_ROW : ROW_W'(i_row_in);
                r_req_col <= (int'(i_column_in) >= COLUMNS) ? LAST_COL
                                                            : COL_W'(i_column_in);
            end
            if (r_state == S_EXEC) begin
                r_row  <= upd.row;
                r_col  <= upd.col;
                r_idx  <= '0;
                r_fill <= {r_color, SPACE_CODE};
            end
            if (r_state == S_SCRL) begin
                r_idx <= (r_idx == LAST_COPY) ? FILL_START : idx_next;
            end
            if (r_state == S_FILL) begin
                r_idx <= idx_next;
                if (r_idx == LAST_CELL) r_init <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_cell_word <= (r_op == OP_READ) ? r_rdata : 16'd0;
                r_out_row   <= 5'(r_row);
                r_out_col   <= 7'(r_col);
                r_out_pos   <= 11'(int'(r_row) * COLUMNS + int'(r_col));
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_EXEC))
        else $error("accepted request did not start execution");

    a_cursor_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_EXEC) |=> ($stable(r_row) && $stable(r_col)))
        else $error("cursor moved outside execution");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_FINISH))
        else $error("result raised without a finished request");

    a_no_result_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |=> !$rose(o_out_valid))
        else $error("result produced during clearing pass");
`endif

endmodule

// ===== hdl/tcw_cursor.sv =====
module tcw_cursor
    import tcw_pkg::*;
(
    input  logic [1:0]       i_op,
    input  logic [7:0]       i_char,
    input  logic [ROW_W-1:0] i_row,
    input  logic [COL_W-1:0] i_col,
    input  logic [ROW_W-1:0] i_req_row,
    input  logic [COL_W-1:0] i_req_col,
    input  logic [7:0]       i_color,
    output t_cursor_upd      o_upd
);

    always_comb begin
        o_upd         = '0;
        o_upd.row     = i_row;
        o_upd.col     = i_col;
        o_upd.wr_row  = i_row;
        o_upd.wr_col  = i_col;
        o_upd.wr_data = {i_color, i_char};
        unique case (i_op)
            OP_PUT: begin
                if (i_char == NEWLINE_CODE) begin
                    o_upd.col = '0;
                    if (i_row == LAST_ROW) begin
                        o_upd.scroll = 1'b1;
                    end else begin
                        o_upd.row = i_row + 1'b1;
                    end
                end else if (i_char == BACKSPACE_CODE) begin
                    if (i_col != '0) begin
                        o_upd.col = i_col - 1'b1;
                    end else if (i_row != '0) begin
                        o_upd.row = i_row - 1'b1;
                        o_upd.col = LAST_COL;
                    end
                    o_upd.wr_en   = 1'b1;
                    o_upd.wr_row  = o_upd.row;
                    o_upd.wr_col  = o_upd.col;
                    o_upd.wr_data = {i_color, SPACE_CODE};
                end else begin
                    o_upd.wr_en = 1'b1;
                    if (i_col == LAST_COL) begin
                        o_upd.col = '0;
                        if (i_row == LAST_ROW) begin
                            o_upd.scroll = 1'b1;
                        end else begin
                            o_upd.row = i_row + 1'b1;
                        end
                    end else begin
                        o_upd.col = i_col + 1'b1;
                    end
                end
            end
            OP_SET: begin
                o_upd.row = i_req_row;
                o_upd.col = i_req_col;
            end
            OP_READ: begin
                o_upd.rd = 1'b1;
            end
            OP_CLEAR: begin
                o_upd.row   = '0;
                o_upd.col   = '0;
                o_upd.clear = 1'b1;
            end
            default: begin
                o_upd.rd = 1'b0;
            end
        endcase
    end

endmodule
